FILE: design/mmke_pkg.sv
// ----------------------------------------------------------------------------
// mmke_pkg
// Types and constants shared by the MIDI message to key event decoder.
// ----------------------------------------------------------------------------
package mmke_pkg;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_CONSUMED = 3'd1,
    ACT_PRESS    = 3'd2,
    ACT_RELEASE  = 3'd3,
    ACT_BEND     = 3'd4,
    ACT_START    = 3'd5,
    ACT_STOP     = 3'd6
  } action_t;

  localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_POLY_PRESS = 4'hA;
  localparam logic [3:0] CMD_CONTROL    = 4'hB;
  localparam logic [3:0] CMD_PITCH_BEND = 4'hE;
  localparam logic [3:0] CMD_SYSTEM     = 4'hF;

  localparam logic [3:0] SYS_SYSEX    = 4'h0;
  localparam logic [3:0] SYS_TICK     = 4'h6;
  localparam logic [3:0] SYS_START    = 4'hA;
  localparam logic [3:0] SYS_CONTINUE = 4'hB;
  localparam logic [3:0] SYS_STOP     = 4'hC;
  localparam logic [3:0] SYS_RESET    = 4'hF;

  localparam logic [1:0] REG_RECORD_OPTIONS = 2'd0;
  localparam logic [1:0] REG_MIDDLE_C_NOTE  = 2'd1;
  localparam logic [1:0] REG_AMPLIFICATION  = 2'd2;

  localparam logic [2:0] RECORD_OPTIONS_RESET = 3'd6;
  localparam logic [6:0] MIDDLE_C_RESET       = 7'd60;
  localparam logic [7:0] AMPLIFICATION_RESET  = 8'd100;

  localparam int OPT_DISABLE  = 0;
  localparam int OPT_NOTE_OFF = 1;
  localparam int OPT_VELOCITY = 2;

  localparam logic [7:0]  FIXED_VOLUME    = 8'd128;
  localparam logic [9:0]  NOTE_OFFSET     = 10'd60;
  // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for all 16-bit p
  localparam logic [16:0] RECIP_100       = 17'd83887;
  localparam int          RECIP_SHIFT     = 23;
  localparam logic [9:0]  VOLUME_MAX      = 10'd511;
  localparam logic [9:0]  MINUS_ONE       = 10'h3FF;

  typedef struct packed {
    logic [2:0] record_options;
    logic [6:0] middle_c_note;
    logic [7:0] amplification_percent;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [7:0]  message_length;
    logic [15:0] product;
  } item_t;

  typedef struct packed {
    logic [7:0] bend_value;
    logic [9:0] key_volume;
    logic [9:0] key_note;
    logic [4:0] channel_number;
    action_t    action;
  } result_t;

endpackage

FILE: design/mmke_cfg.sv
// ----------------------------------------------------------------------------
// mmke_cfg
// Configuration register file: record options, middle-C note, amplification.
// ----------------------------------------------------------------------------
module mmke_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output mmke_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.record_options        <= mmke_pkg::RECORD_OPTIONS_RESET;
      cfg.middle_c_note         <= mmke_pkg::MIDDLE_C_RESET;
      cfg.amplification_percent <= mmke_pkg::AMPLIFICATION_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmke_pkg::REG_RECORD_OPTIONS: cfg.record_options        <= cfg_data[2:0];
        mmke_pkg::REG_MIDDLE_C_NOTE:  cfg.middle_c_note         <= cfg_data[6:0];
        mmke_pkg::REG_AMPLIFICATION:  cfg.amplification_percent <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/mmke_decode.sv
// ----------------------------------------------------------------------------
// mmke_decode
// Message decode, note shift and volume divide by 100 with saturation.
// ----------------------------------------------------------------------------
module mmke_decode (
  input  mmke_pkg::item_t   item,
  input  mmke_pkg::cfg_t    cfg,
  output mmke_pkg::result_t result
);

  logic [3:0]  cmd;
  logic [3:0]  sub;
  logic [32:0] scaled;
  logic [9:0]  quotient;
  logic [9:0]  volume;
  logic [9:0]  note;
  logic [4:0]  chan;

  assign cmd      = item.status_byte[7:4];
  assign sub      = item.status_byte[3:0];
  assign scaled   = {17'd0, item.product} * {16'd0, mmke_pkg::RECIP_100};
  assign quotient = scaled[mmke_pkg::RECIP_SHIFT +: 10];
  assign volume   = (quotient > mmke_pkg::VOLUME_MAX) ? mmke_pkg::VOLUME_MAX : quotient;
  assign note     = {2'd0, item.first_data} + 10'd1 + {3'd0, cfg.middle_c_note}
                    - mmke_pkg::NOTE_OFFSET;
  assign chan     = {1'b0, sub} + 5'd1;

  always_comb begin
    result = '{bend_value: 8'd0, key_volume: 10'd0, key_note: 10'd0,
               channel_number: 5'd0, action: mmke_pkg::ACT_NONE};
    if (item.message_length != 8'd0 && !cfg.record_options[mmke_pkg::OPT_DISABLE]) begin
      case (cmd)
        mmke_pkg::CMD_NOTE_OFF, mmke_pkg::CMD_NOTE_ON, mmke_pkg::CMD_POLY_PRESS: begin
          if (cmd == mmke_pkg::CMD_NOTE_ON && item.second_data != 8'd0) begin
            result.action         = mmke_pkg::ACT_PRESS;
            result.channel_number = chan;
            result.key_note       = note;
            result.key_volume     = volume;
          end else if (cfg.record_options[mmke_pkg::OPT_NOTE_OFF]) begin
            result.action         = mmke_pkg::ACT_RELEASE;
            result.channel_number = chan;
            result.key_note       = note;
            result.key_volume     = volume;
          end else begin
            result.action = mmke_pkg::ACT_CONSUMED;
          end
        end
        mmke_pkg::CMD_CONTROL: result.action = mmke_pkg::ACT_CONSUMED;
        mmke_pkg::CMD_PITCH_BEND: begin
          result.action         = mmke_pkg::ACT_BEND;
          result.channel_number = chan;
          result.key_note       = mmke_pkg::MINUS_ONE;
          result.key_volume     = mmke_pkg::MINUS_ONE;
          result.bend_value     = item.first_data;
        end
        mmke_pkg::CMD_SYSTEM: begin
          case (sub)
            mmke_pkg::SYS_SYSEX: begin
              if (item.message_length > 8'd2) result.action = mmke_pkg::ACT_CONSUMED;
            end
            mmke_pkg::SYS_TICK: ;
            mmke_pkg::SYS_START, mmke_pkg::SYS_CONTINUE: result.action = mmke_pkg::ACT_START;
            mmke_pkg::SYS_STOP, mmke_pkg::SYS_RESET:     result.action = mmke_pkg::ACT_STOP;
            default: result.action = mmke_pkg::ACT_CONSUMED;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/midi_message_to_key_event.sv
// ----------------------------------------------------------------------------
// midi_message_to_key_event
// Decodes one complete MIDI message per beat into one key-recording action.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the velocity * amplification
//   product is formed ahead of the input register, the divide by 100 after
//   it.
// Throughput: one message per cycle while m_tready holds; the result register frees as it drains.
// Reset: synchronous; clears both valid flags and loads register defaults.
module midi_message_to_key_event (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // status_byte[7:0], first_data[15:8], second_data[23:16], message_length[31:24]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // action[2:0], channel_number[7:3], key_note[17:8], key_volume[27:18],
  // bend_value[35:28], zero[39:36]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  mmke_pkg::cfg_t    cfg;
  mmke_pkg::item_t   item;
  mmke_pkg::item_t   item_next;
  mmke_pkg::result_t result;
  mmke_pkg::result_t result_next;
  logic              item_valid;
  logic              out_free;
  logic              item_free;
  logic [7:0]        len_in;
  logic [7:0]        d2_in;
  logic [7:0]        vel_in;

  mmke_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign len_in = s_tdata[31:24];
  assign d2_in  = (len_in >= 8'd3) ? s_tdata[23:16] : 8'd0;
  assign vel_in = !cfg.record_options[mmke_pkg::OPT_VELOCITY] ? mmke_pkg::FIXED_VOLUME :
                  (s_tdata[7:4] == mmke_pkg::CMD_NOTE_OFF) ? 8'd0 : d2_in;

  always_comb begin
    item_next.status_byte    = s_tdata[7:0];
    item_next.first_data     = (len_in >= 8'd2) ? s_tdata[15:8] : 8'd0;
    item_next.second_data    = d2_in;
    item_next.message_length = len_in;
    item_next.product        = {8'd0, vel_in} * {8'd0, cfg.amplification_percent};
  end

  mmke_decode u_decode (
    .item   (item),
    .cfg    (cfg),
    .result (result_next)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign item_free = !item_valid || out_free;
  assign s_tready  = item_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (item_free) item_valid <= s_tvalid;
      if (out_free)  m_tvalid   <= item_valid;
    end
    if (item_free && s_tvalid) item <= item_next;
    if (out_free && item_valid) result <= result_next;
  end

  assign m_tdata = {4'd0, result};

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (item_valid && m_tvalid && !m_tready))
    else $error("input stalled without a full pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_bend_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.action == mmke_pkg::ACT_BEND) |->
    (result.key_note == mmke_pkg::MINUS_ONE && result.key_volume == mmke_pkg::MINUS_ONE))
    else $error("bend result with bad note or volume");

  a_volume_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (result.action == mmke_pkg::ACT_PRESS ||
                  result.action == mmke_pkg::ACT_RELEASE)) |-> !result.key_volume[9])
    else $error("key volume above saturation limit");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_free) |=> m_tvalid)
    else $error("item lost between stages");

endmodule
